// ===== rtl/core/fhps_pkg.sv =====
// Shared types and constants for the fractional half-period synthesiser.
`timescale 1ns / 1ps

package fhps_pkg;

  localparam int FRAC_BITS = 24;

  // Field and register widths.
  localparam int CLK_W = 29;
  localparam int DLY_W = 4;
  localparam int HZ_W  = 26;
  localparam int MHZ_W = 11;
  localparam int CNT_OUT_W = 8;
  localparam int ST_W  = 2;
  localparam int ADDR_W = 1;

  // Divider widths: clk_hz * 1000 fits 39 bits, the denominator 38 bits when positive.
  localparam int NUM_W = 39;
  localparam int DEN_W = 40;
  localparam int REM_W = 38;
  localparam int Q_W   = 31;
  localparam int DIV_W = NUM_W + FRAC_BITS;
  localparam int STEP_W = $clog2(DIV_W);

  localparam logic [CLK_W-1:0] CLK_HZ_RST = CLK_W'(125000000);
  localparam logic [DLY_W-1:0] DELAY_RST  = DLY_W'(4);

  // Register indexes.
  localparam logic [ADDR_W-1:0] REG_CLK_HZ = 1'b0;
  localparam logic [ADDR_W-1:0] REG_DELAY  = 1'b1;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_REJECT = 2'd1;
  localparam logic [ST_W-1:0] ST_SAT    = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic tick;    // tick word accepted this cycle
    logic start;   // set word accepted: load numerator and denominator
    logic step;    // one restoring division step
    logic finish;  // round, commit and post the set result
  } cmd_t;

  typedef struct packed {
    logic out_free;  // output register empty or being taken
  } stat_t;

endpackage

// ===== rtl/core/fhps_ctrl.sv =====
// Sequencer for the fractional half-period synthesiser.
`timescale 1ns / 1ps

module fhps_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 req_type,
  input  fhps_pkg::stat_t      stat,
  output logic                 in_tready,
  output fhps_pkg::cmd_t       cmd
);

  fhps_pkg::state_t                 state_r, state_nxt;
  logic [fhps_pkg::STEP_W-1:0]      cnt_r, cnt_nxt;
  logic                             accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fhps_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    accept    = 1'b0;
    unique case (state_r)
      fhps_pkg::S_IDLE: begin
        in_tready  = stat.out_free;
        accept     = in_tvalid && stat.out_free;
        cmd.tick   = accept && !req_type;
        cmd.start  = accept && req_type;
        if (accept && req_type) begin
          state_nxt = fhps_pkg::S_DIV;
          cnt_nxt   = fhps_pkg::STEP_W'(fhps_pkg::DIV_W - 1);
        end
      end
      fhps_pkg::S_DIV: begin
        cmd.step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = fhps_pkg::S_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      fhps_pkg::S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = fhps_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fhps_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/fhps_datapath.sv =====
// Datapath: config registers, period state, tick arithmetic, serial divider, output word.
`timescale 1ns / 1ps

module fhps_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [fhps_pkg::ADDR_W-1:0]        cfg_addr,
  input  logic [fhps_pkg::CLK_W-1:0]         cfg_wdata,
  input  logic [fhps_pkg::HZ_W-1:0]          freq_hz,
  input  logic signed [fhps_pkg::MHZ_W-1:0]  freq_millihz,
  input  fhps_pkg::cmd_t                     cmd,
  output fhps_pkg::stat_t                    stat,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [fhps_pkg::CNT_OUT_W-1:0]     half_period_count,
  output logic [fhps_pkg::ST_W-1:0]          status
);

  localparam int F = fhps_pkg::FRAC_BITS;

  logic [fhps_pkg::CLK_W-1:0]      clk_hz_r;
  logic [fhps_pkg::DLY_W-1:0]      delay_r;
  logic [31:0]                     period_r, period_nxt;
  logic [31:0]                     err_r, err_nxt;

  logic [fhps_pkg::DIV_W-1:0]      num_r, num_nxt;
  logic [fhps_pkg::DEN_W-1:0]      den_r, den_nxt;
  logic [fhps_pkg::REM_W-1:0]      rem_r, rem_nxt;
  logic [fhps_pkg::Q_W-1:0]        q_r, q_nxt;
  logic                            ovf_r, ovf_nxt;

  logic                            ov_r, ov_nxt;
  logic [fhps_pkg::CNT_OUT_W-1:0]  cnt_out_r, cnt_out_nxt;
  logic [fhps_pkg::ST_W-1:0]       st_out_r, st_out_nxt;

  logic [31:0]                     diff, wc;
  logic [fhps_pkg::NUM_W-1:0]      num_val;
  logic [fhps_pkg::REM_W:0]        trial;
  logic [fhps_pkg::REM_W:0]        den_ext;
  logic                            den_pos, round_up, reject;
  logic [31:0]                     q_rnd;

  // Config registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= fhps_pkg::CLK_HZ_RST;
      delay_r  <= fhps_pkg::DELAY_RST;
    end else if (cfg_we) begin
      if (cfg_addr == fhps_pkg::REG_CLK_HZ) begin
        clk_hz_r <= cfg_wdata;
      end else if (cfg_addr == fhps_pkg::REG_DELAY) begin
        delay_r <= cfg_wdata[fhps_pkg::DLY_W-1:0];
      end
    end
  end

  // Tick: whole cycles from period less carried error; error keeps the fraction.
  assign diff = period_r - err_r;
  assign wc   = diff >> F;

  // Set: operands, then one quotient bit per step.
  assign num_val = fhps_pkg::NUM_W'(clk_hz_r) * fhps_pkg::NUM_W'(1000);
  assign den_ext = {1'b0, den_r[fhps_pkg::REM_W-1:0]};
  assign trial   = {rem_r, num_r[fhps_pkg::DIV_W-1]};
  assign den_pos = !den_r[fhps_pkg::DEN_W-1] && (den_r != '0);
  assign round_up = ({rem_r, 1'b0} >= den_ext);
  assign q_rnd    = 32'(q_r) + 32'(round_up);
  assign reject   = !den_pos || ovf_r || q_rnd[31];

  always_comb begin
    period_nxt = period_r;
    err_nxt    = err_r;
    num_nxt    = num_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    q_nxt      = q_r;
    ovf_nxt    = ovf_r;

    if (cmd.tick) begin
      err_nxt = err_r + (wc << F) - period_r;
    end
    if (cmd.start) begin
      num_nxt = {num_val, {F{1'b0}}};
      den_nxt = fhps_pkg::DEN_W'(freq_hz) * fhps_pkg::DEN_W'(2000)
              + {{(fhps_pkg::DEN_W-fhps_pkg::MHZ_W-1){freq_millihz[fhps_pkg::MHZ_W-1]}},
                 freq_millihz, 1'b0};
      rem_nxt = '0;
      q_nxt   = '0;
      ovf_nxt = 1'b0;
    end
    if (cmd.step) begin
      num_nxt = {num_r[fhps_pkg::DIV_W-2:0], 1'b0};
      ovf_nxt = ovf_r | q_r[fhps_pkg::Q_W-1];
      if (trial >= den_ext) begin
        rem_nxt = fhps_pkg::REM_W'(trial - den_ext);
        q_nxt   = {q_r[fhps_pkg::Q_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[fhps_pkg::REM_W-1:0];
        q_nxt   = {q_r[fhps_pkg::Q_W-2:0], 1'b0};
      end
    end
    if (cmd.finish && !reject) begin
      period_nxt = q_rnd - (32'(delay_r) << F);
    end
  end

  // Output word register.
  always_comb begin
    ov_nxt      = ov_r && !out_tready;
    cnt_out_nxt = cnt_out_r;
    st_out_nxt  = st_out_r;
    if (cmd.tick) begin
      ov_nxt = 1'b1;
      if (wc > 32'd255) begin
        cnt_out_nxt = '1;
        st_out_nxt  = fhps_pkg::ST_SAT;
      end else begin
        cnt_out_nxt = wc[fhps_pkg::CNT_OUT_W-1:0];
        st_out_nxt  = fhps_pkg::ST_OK;
      end
    end else if (cmd.finish) begin
      ov_nxt      = 1'b1;
      cnt_out_nxt = '0;
      st_out_nxt  = reject ? fhps_pkg::ST_REJECT : fhps_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      err_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      period_r <= period_nxt;
      err_r    <= err_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    rem_r     <= rem_nxt;
    q_r       <= q_nxt;
    ovf_r     <= ovf_nxt;
    cnt_out_r <= cnt_out_nxt;
    st_out_r  <= st_out_nxt;
  end

  assign stat.out_free     = !ov_r || out_tready;
  assign out_tvalid        = ov_r;
  assign half_period_count = cnt_out_r;
  assign status            = st_out_r;

endmodule

// ===== rtl/core/fractional_half_period_synth.sv =====
// Top level of the fractional half-period synthesiser.
`timescale 1ns / 1ps
//
//  channel | dir | handshake        | word
//  --------+-----+------------------+-----------------------------------------------
//  in_     | in  | tvalid/tready    | tuser: req_type; tdata: freq_hz, freq_millihz
//  out_    | out | tvalid/tready    | tdata: half_period_count, status
//  cfg_    | in  | we (no wait)     | addr 0 clk_hz, addr 1 delay_cycles
//
//  A tick word is worked out in the accept cycle and lands in the output register,
//  so ticks go through at one word per cycle while the output is taken.
//  A set word goes through S_DIV and then S_FIN: the bit-serial restoring divider yields one
//  quotient bit per cycle over the 39 + FRAC_BITS numerator bits, then rounds.
//  in_tready drops while a set word is in the divider or the output word is stalled.
//  Reset (rst_n low, synchronous) clears period, error and the output valid flag and
//  loads clk_hz = 125 MHz, delay_cycles = 4.

module fractional_half_period_synth (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic                           in_tuser,   // [0] req_type
  input  logic [39:0]                    in_tdata,   // [25:0] freq_hz, [36:26] freq_millihz
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,  // [7:0] half_period_count, [9:8] status
  input  logic                           cfg_we,
  input  logic [fhps_pkg::ADDR_W-1:0]    cfg_addr,
  input  logic [fhps_pkg::CLK_W-1:0]     cfg_wdata
);

  fhps_pkg::cmd_t                      cmd;
  fhps_pkg::stat_t                     stat;
  logic [fhps_pkg::CNT_OUT_W-1:0]      half_period_count;
  logic [fhps_pkg::ST_W-1:0]           status;

  fhps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .req_type  (in_tuser),
    .stat      (stat),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  fhps_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .freq_hz           (in_tdata[25:0]),
    .freq_millihz      ($signed(in_tdata[36:26])),
    .cmd               (cmd),
    .stat              (stat),
    .out_tready        (out_tready),
    .out_tvalid        (out_tvalid),
    .half_period_count (half_period_count),
    .status            (status)
  );

  assign out_tdata = {6'b0, status, half_period_count};

  // A stalled output word must hold back new input.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while output word stalled");

  // A tick word shows up at the output on the next cycle.
  a_tick_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser) |=> out_tvalid)
    else $error("tick word produced no output");

  // A set word occupies the divider: no new word the cycle after.
  a_set_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |=> !in_tready)
    else $error("input accepted during divide");

endmodule

// ===== tb/fhps_checker.sv =====
// Request-type codes and the watching, predicting and comparing checker.
`timescale 1ns / 1ps

package fhps_tb_pkg;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_SET  = 1'b1
  } req_t;

endpackage

module fhps_checker
  import fhps_pkg::*;
  import fhps_tb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic                 in_tuser,
  input  logic [39:0]          in_tdata,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [15:0]          out_tdata,
  input  logic                 cfg_we,
  input  logic [ADDR_W-1:0]    cfg_addr,
  input  logic [CLK_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic [CNT_OUT_W-1:0] count;
    logic [ST_W-1:0]      status;
  } half_period_t;

  half_period_t      half_period_q[$];
  logic [CLK_W-1:0]  clk_hz_cfg;
  logic [DLY_W-1:0]  delay_cfg;
  logic [31:0]       period_fx;   // half period, FRAC_BITS fraction, delay taken off
  logic [31:0]       phase_err;   // carried fraction error
  int                fails = 0;

  assign fail_count = fails;

  // Works out the word for one accepted request and moves the period/error state on.
  function automatic half_period_t next_half_period(input req_t req,
                                                    input logic [HZ_W-1:0] hz,
                                                    input logic signed [MHZ_W-1:0] mhz);
    half_period_t res;
    longint       den;
    logic [63:0]  num;
    logic [63:0]  quot;
    logic [31:0]  whole;
    res.count  = '0;
    res.status = ST_OK;
    if (req == REQ_SET) begin
      den = 2000 * longint'(hz) + 2 * longint'(mhz);
      if (den <= 0) begin
        res.status = ST_REJECT;
      end else begin
        // rounded (clk * 1000 * 2^FRAC_BITS) / den, exact in 64 bits
        num  = (64'(clk_hz_cfg) * 64'd1000) << FRAC_BITS;
        quot = (num + 64'(den >>> 1)) / 64'(den);
        if (quot >= 64'h8000_0000) begin
          res.status = ST_REJECT;
        end else begin
          period_fx = quot[31:0] - (32'(delay_cfg) << FRAC_BITS);
        end
      end
    end else begin
      whole     = (period_fx - phase_err) >> FRAC_BITS;
      phase_err = phase_err + (whole << FRAC_BITS) - period_fx;
      if (whole > 32'd255) begin
        res.count  = '1;
        res.status = ST_SAT;
      end else begin
        res.count = whole[CNT_OUT_W-1:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    half_period_t got;
    half_period_t want;
    if (!rst_n) begin
      clk_hz_cfg = CLK_HZ_RST;
      delay_cfg  = DELAY_RST;
      period_fx  = '0;
      phase_err  = '0;
      half_period_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_CLK_HZ: clk_hz_cfg = cfg_wdata;
          REG_DELAY:  delay_cfg  = cfg_wdata[DLY_W-1:0];
          default: ;
        endcase
      end
      // push before pop: the queue stays in order either way
      if (in_tvalid && in_tready) begin
        half_period_q.push_back(next_half_period(req_t'(in_tuser), in_tdata[HZ_W-1:0],
                                                 in_tdata[HZ_W +: MHZ_W]));
      end
      if (out_tvalid && out_tready) begin
        got.count  = out_tdata[CNT_OUT_W-1:0];
        got.status = out_tdata[CNT_OUT_W +: ST_W];
        if (half_period_q.size() == 0) begin
          $error("unexpected result word: count %0d status %0d", got.count, got.status);
          fails++;
        end else begin
          want = half_period_q.pop_front();
          if (got.count !== want.count) begin
            $error("half_period_count: expected %0d, got %0d", want.count, got.count);
            fails++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fails++;
          end
        end
      end
    end
    pending = half_period_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Stimulus, clock, reset and verdict for the fractional half-period synthesiser.
`timescale 1ns / 1ps

module tb_top;
  import fhps_pkg::*;
  import fhps_tb_pkg::*;

  // The tail outlasts a set word's pass through the divider, with a margin on top.
  localparam int TAIL_CYCLES  = 100;
  localparam int BLOCK_WORDS  = 272;
  localparam int NUM_SETTINGS = 6;

  typedef struct {
    logic [CLK_W-1:0] clk_hz;
    logic [DLY_W-1:0] delay;
  } setting_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic                in_tuser = 1'b0;
  logic [39:0]         in_tdata = '0;   // [25:0] freq_hz, [36:26] freq_millihz
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [15:0]         out_tdata;       // [7:0] half_period_count, [9:8] status
  logic                cfg_we = 1'b0;
  logic [ADDR_W-1:0]   cfg_addr = '0;
  logic [CLK_W-1:0]    cfg_wdata = '0;

  int                  fail_count;
  int                  pending;

  // Idle rates in percent; the top moves them on as words go in.
  int unsigned         send_idle_pct = 27;
  int unsigned         recv_idle_pct = 80;
  int unsigned         words_sent = 0;
  logic [CLK_W-1:0]    clk_now = CLK_HZ_RST;
  logic [DLY_W-1:0]    delay_now = DELAY_RST;

  setting_t            settings[NUM_SETTINGS];

  fractional_half_period_synth dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  fhps_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Idling schedule: sender-light/receiver-heavy, then swapped, then flat out.
  always @(posedge clk) begin
    if (words_sent < 550) begin
      send_idle_pct <= 27;
      recv_idle_pct <= 80;
    end else if (words_sent < 1100) begin
      send_idle_pct <= 80;
      recv_idle_pct <= 27;
    end else begin
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #(5_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // One request word; tvalid stays high into the next word unless a gap is drawn.
  task automatic send_word(input req_t req, input logic [HZ_W-1:0] hz,
                           input logic [MHZ_W-1:0] mhz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {3'b000, mhz, hz};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // Stop sending and let every outstanding word come back, then a settling tail.
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Both registers back to back, so cfg_we is only lowered after the pair.
  task automatic write_config(input setting_t s);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_CLK_HZ;
    cfg_wdata <= s.clk_hz;
    @(posedge clk);
    cfg_addr  <= REG_DELAY;
    cfg_wdata <= CLK_W'(s.delay);
    @(posedge clk);
    cfg_we    <= 1'b0;
    clk_now   = s.clk_hz;
    delay_now = s.delay;
    @(posedge clk);
  endtask

  // Target hertz that mostly lands the count inside 0..255 for the current clock.
  function automatic logic [HZ_W-1:0] pick_hz();
    longint lo;
    longint hi;
    case ($urandom_range(9))
      6, 9:    return HZ_W'($urandom);
      7:       return HZ_W'($urandom_range(2000));
      8:       return HZ_W'($urandom_range(40_000_000));
      default: begin
        lo = longint'(clk_now) / (2 * (260 + longint'(delay_now)));
        hi = longint'(clk_now) / 2;
        if (hi > 64'h3FF_FFFF) hi = 64'h3FF_FFFF;
        if (lo > hi) lo = hi;
        return HZ_W'($urandom_range(int'(hi), int'(lo)));
      end
    endcase
  endfunction

  function automatic logic [MHZ_W-1:0] pick_mhz();
    if ($urandom_range(1)) return MHZ_W'(int'($urandom_range(1998)) - 999);
    return MHZ_W'($urandom);
  endfunction

  initial begin
    settings[0] = '{clk_hz: 1_000_000,     delay: 0};
    settings[1] = '{clk_hz: 300_000_000,   delay: 15};
    settings[2] = '{clk_hz: 0,             delay: 9};
    settings[3] = '{clk_hz: 29'h1FFF_FFFF, delay: 15};
    settings[4] = '{clk_hz: 50_000_000,    delay: 1};
    settings[5] = '{clk_hz: 125_000_000,   delay: 4};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words on the reset setting (125 MHz, delay 4).
    send_word(REQ_TICK, '0, '0);                          // period still zero
    send_word(REQ_SET, 26'd1000, '0);                     // quotient too wide
    send_word(REQ_SET, '0, '0);                           // zero denominator
    send_word(REQ_SET, '0, MHZ_W'(-999));                 // negative denominator
    send_word(REQ_SET, 26'd1, 11'h400);                   // most negative mHz
    send_word(REQ_SET, '0, 11'h3FF);                      // tiny positive den
    send_word(REQ_SET, 26'd10_000_000, '0);               // 2.25 cycles
    repeat (4) send_word(REQ_TICK, '0, '0);
    send_word(REQ_SET, '1, 11'h400);                      // delay exceeds period
    send_word(REQ_TICK, '1, '1);
    send_word(REQ_TICK, '0, '0);
    send_word(REQ_SET, 26'd200_000, '0);                  // count above 255
    send_word(REQ_TICK, '0, '0);
    send_word(REQ_SET, 26'd40_000_000, MHZ_W'(999));
    send_word(REQ_TICK, '0, '0);
    send_word(REQ_SET, 26'd333_333, MHZ_W'(777));
    repeat (3) send_word(REQ_TICK, '1, '0);
    send_word(REQ_SET, 26'd12_345_678, MHZ_W'(-500));
    repeat (2) send_word(REQ_TICK, '0, '1);

    // Random blocks, one per register setting; config only once fully drained.
    for (int b = 0; b < NUM_SETTINGS; b++) begin
      drain();
      write_config(settings[b]);
      send_word(REQ_SET, pick_hz(), pick_mhz());
      for (int n = 1; n < BLOCK_WORDS; n++) begin
        if ($urandom_range(99) < 12) begin
          send_word(REQ_SET, pick_hz(), pick_mhz());
        end else begin
          send_word(REQ_TICK, HZ_W'($urandom), MHZ_W'($urandom));
        end
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
